### rtl/csvp_pkg.sv
package csvp_pkg;

    // Field widths
    localparam int BYTE_W  = 8;
    localparam int VALUE_W = 32;
    localparam int INDEX_W = 17;
    localparam int FRAME_W = 16;
    localparam int COUNT_W = 18;
    localparam int MAG_W   = 32;
    localparam int PROD_W  = 36;

    // Point capacity: the smaller of the configured maximum and the index span.
    localparam int MAX_POINTS = 131072;
    localparam int INDEX_SPAN = 131072;
    localparam int CAP_POINTS = (MAX_POINTS < INDEX_SPAN) ? MAX_POINTS : INDEX_SPAN;
    localparam logic [COUNT_W-1:0] CAPACITY = COUNT_W'(CAP_POINTS);

    // Magnitude limits for a positive and a negative field.
    localparam logic [MAG_W-1:0] POS_LIMIT = 32'h7FFF_FFFF;
    localparam logic [MAG_W-1:0] NEG_LIMIT = 32'h8000_0000;

    // Characters of interest
    localparam logic [BYTE_W-1:0] CH_COMMA   = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB     = 8'h09;
    localparam logic [BYTE_W-1:0] CH_VTAB    = 8'h0B;
    localparam logic [BYTE_W-1:0] CH_FFEED   = 8'h0C;
    localparam logic [BYTE_W-1:0] CH_CR      = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_PLUS    = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_MINUS   = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE    = 8'h39;

    // Field conversion phases
    localparam logic [1:0] PH_SKIP   = 2'd0;
    localparam logic [1:0] PH_SIGN   = 2'd1;
    localparam logic [1:0] PH_DIGITS = 2'd2;
    localparam logic [1:0] PH_STOP   = 2'd3;

    // Result of the field converter for the byte in hand.
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               saturated;
    } t_field_res;

    // Position of the field that the byte in hand closes.
    typedef struct packed {
        logic [INDEX_W-1:0] point_index;
        logic               beyond;
    } t_index_res;

    // A comma or a newline closes a field.
    function automatic logic is_delim(input logic [BYTE_W-1:0] b);
        return (b == CH_COMMA) || (b == CH_NEWLINE);
    endfunction

endpackage

### rtl/csvp_field.sv
module csvp_field
    import csvp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic              i_first_byte,
    output t_field_res        o_res
);

    logic [1:0]        r_phase, n_phase;
    logic              r_neg, n_neg;
    logic [MAG_W-1:0]  r_mag, n_mag;
    logic              r_ovf, n_ovf;

    logic [1:0]        cur_phase;
    logic              cur_neg;
    logic [MAG_W-1:0]  cur_mag;
    logic              cur_ovf;
    logic              is_blank;
    logic              is_sign;
    logic              is_digit;
    logic [MAG_W-1:0]  limit;
    logic [PROD_W-1:0] prod;

    // A new file starts from a cleared field.
    always_comb begin
        cur_phase = i_first_byte ? PH_SKIP : r_phase;
        cur_neg   = i_first_byte ? 1'b0 : r_neg;
        cur_mag   = i_first_byte ? '0 : r_mag;
        cur_ovf   = i_first_byte ? 1'b0 : r_ovf;
    end

    // Character classes.
    assign is_blank = (i_data_byte == CH_SPACE) || (i_data_byte == CH_TAB) ||
                      (i_data_byte == CH_VTAB) || (i_data_byte == CH_FFEED) ||
                      (i_data_byte == CH_CR);
    assign is_sign  = (i_data_byte == CH_PLUS) || (i_data_byte == CH_MINUS);
    assign is_digit = (i_data_byte >= CH_ZERO) && (i_data_byte <= CH_NINE);

    // Accumulate one decimal digit: mag * 10 + digit as two shifts and two adds.
    assign limit = cur_neg ? NEG_LIMIT : POS_LIMIT;
    assign prod  = ({4'b0, cur_mag} << 3) + ({4'b0, cur_mag} << 1)
                 + {32'b0, i_data_byte[3:0]};

    // The finished field's value, taken when the byte is a delimiter.
    assign o_res.value     = cur_neg ? (32'd0 - cur_mag) : cur_mag;
    assign o_res.saturated = cur_ovf;

    // Next field state.
    always_comb begin
        n_phase = cur_phase;
        n_neg   = cur_neg;
        n_mag   = cur_mag;
        n_ovf   = cur_ovf;
        priority if (is_delim(i_data_byte)) begin
            n_phase = PH_SKIP;
            n_neg   = 1'b0;
            n_mag   = '0;
            n_ovf   = 1'b0;
        end else if (cur_phase == PH_SKIP && is_blank) begin
            n_phase = PH_SKIP;
        end else if (cur_phase == PH_SKIP && is_sign) begin
            n_neg   = (i_data_byte == CH_MINUS);
            n_phase = PH_SIGN;
        end else if (cur_phase != PH_STOP && is_digit) begin
            n_phase = PH_DIGITS;
            if (prod > {4'b0, limit}) begin
                n_mag = limit;
                n_ovf = 1'b1;
            end else begin
                n_mag = prod[MAG_W-1:0];
            end
        end else begin
            n_phase = PH_STOP;
        end
    end

    // Field state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SKIP;
            r_neg   <= 1'b0;
            r_mag   <= '0;
            r_ovf   <= 1'b0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_neg   <= n_neg;
            r_mag   <= n_mag;
            r_ovf   <= n_ovf;
        end
    end

endmodule

### rtl/csvp_count.sv
module csvp_count
    import csvp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic       i_delim,
    input  logic       i_first_byte,
    output t_index_res o_res
);

    logic [COUNT_W-1:0] r_cnt, n_cnt;
    logic [COUNT_W-1:0] cur_cnt;
    logic               beyond;

    // A new file restarts the count before its first byte is taken.
    assign cur_cnt = i_first_byte ? '0 : r_cnt;
    assign beyond  = (cur_cnt >= CAPACITY);

    assign o_res.beyond      = beyond;
    assign o_res.point_index = beyond ? '0 : cur_cnt[INDEX_W-1:0];

    // Count closed fields, holding at capacity.
    assign n_cnt = (i_delim && !beyond) ? cur_cnt + 1'b1 : cur_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_step) begin
            r_cnt <= n_cnt;
        end
    end

endmodule

### rtl/csv_integer_field_parser.sv
// Channel   Direction  Valid          Stall          Payload
// input     in         i_in_valid     o_in_stall     i_data_byte, i_first_byte
// result    out        o_out_valid    i_out_stall    o_value, o_point_index, o_frame_out,
//                                                    o_saturated, o_beyond_capacity
// config    in         i_cfg_wr_en    -              i_cfg_wr_data (frame index)
//
// One byte per cycle sustained while no delimiter waits on a stalled result. A byte
// is held in the input register and converted by the digit accumulate (shift-add by
// ten and a limit compare); a delimiter's field is then captured in the result register.
// Synchronous active-low reset clears the field state, point count and frame index.
// Only delimiter bytes wait on a stalled result register; other bytes keep flowing.
module csv_integer_field_parser
    import csvp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [BYTE_W-1:0]  i_data_byte,
    input  logic               i_first_byte,
    input  logic               i_cfg_wr_en,
    input  logic [FRAME_W-1:0] i_cfg_wr_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [VALUE_W-1:0] o_value,
    output logic [INDEX_W-1:0] o_point_index,
    output logic [FRAME_W-1:0] o_frame_out,
    output logic               o_saturated,
    output logic               o_beyond_capacity
);

    logic [FRAME_W-1:0] r_frame;
    logic               r_s1_valid;
    logic [BYTE_W-1:0]  r_s1_byte;
    logic               r_s1_first;
    logic               r_out_valid;
    logic [VALUE_W-1:0] r_out_value;
    logic [INDEX_W-1:0] r_out_index;
    logic [FRAME_W-1:0] r_out_frame;
    logic               r_out_sat;
    logic               r_out_beyond;

    logic       s1_delim;
    logic       out_free;
    logic       s1_step;
    logic       in_take;
    t_field_res field_res;
    t_index_res index_res;

    // Frame index register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame <= '0;
        end else if (i_cfg_wr_en) begin
            r_frame <= i_cfg_wr_data;
        end
    end

    // Stage control: a delimiter needs a free result slot, other bytes do not.
    assign s1_delim   = is_delim(r_s1_byte);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_step    = r_s1_valid && (out_free || !s1_delim);
    assign in_take    = i_in_valid && !o_in_stall;
    assign o_in_stall = r_s1_valid && !s1_step;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_take || s1_step) begin
            r_s1_valid <= in_take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_byte  <= i_data_byte;
            r_s1_first <= i_first_byte;
        end
    end

    // Field conversion and point counting.
    csvp_field u_field (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (s1_step),
        .i_data_byte  (r_s1_byte),
        .i_first_byte (r_s1_first),
        .o_res        (field_res)
    );

    csvp_count u_count (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (s1_step),
        .i_delim      (s1_delim),
        .i_first_byte (r_s1_first),
        .o_res        (index_res)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= s1_step && s1_delim;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && s1_step && s1_delim) begin
            r_out_value  <= field_res.value;
            r_out_sat    <= field_res.saturated;
            r_out_index  <= index_res.point_index;
            r_out_beyond <= index_res.beyond;
            r_out_frame  <= r_frame;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_value           = r_out_value;
    assign o_point_index     = r_out_index;
    assign o_frame_out       = r_out_frame;
    assign o_saturated       = r_out_sat;
    assign o_beyond_capacity = r_out_beyond;

    // A field past capacity reports index zero.
    a_beyond_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_beyond_capacity) |-> (o_point_index == '0))
        else $error("beyond-capacity result with nonzero point index");

    // A saturated field carries one of the two 32-bit extremes.
    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_saturated) |->
            (o_value == 32'h7FFF_FFFF || o_value == 32'h8000_0000))
        else $error("saturated result not clamped to an extreme");

    // The input side only stalls while a delimiter waits on a blocked result.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_valid && s1_delim && r_out_valid && i_out_stall))
        else $error("input stalled without a blocked delimiter");

    // A delimiter taken with a free result slot shows up as a result next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_step && s1_delim) |=> o_out_valid)
        else $error("delimiter produced no result");

endmodule

### tb/sv/tb_top.sv
module tb_top;
    import csvp_pkg::*;

    // One request on the byte channel.
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              first;
    } t_byte_req;

    // A parsed field as the block should report it.
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [INDEX_W-1:0] point_index;
        logic [FRAME_W-1:0] frame;
        logic               saturated;
        logic               beyond;
    } t_field_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [BYTE_W-1:0]  i_data_byte = '0;
    logic               i_first_byte = 1'b0;
    logic               i_cfg_wr_en = 1'b0;
    logic [FRAME_W-1:0] i_cfg_wr_data = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [VALUE_W-1:0] o_value;
    logic [INDEX_W-1:0] o_point_index;
    logic [FRAME_W-1:0] o_frame_out;
    logic               o_saturated;
    logic               o_beyond_capacity;

    t_byte_req     byte_reqs[$];
    t_field_result pending_fields[$];
    int            errors = 0;
    bit            no_idle = 1'b0;
    bit            byte_taken = 1'b0;
    int            send_gap = 0;
    int            stall_left = 0;

    // Shadow of the parser state and the frame register.
    logic [FRAME_W-1:0] frame_reg = '0;
    logic [COUNT_W-1:0] points_seen = '0;
    logic [1:0]         phase = PH_SKIP;
    logic               negative = 1'b0;
    logic [MAG_W-1:0]   mag = '0;
    logic               clamped = 1'b0;

    logic [BYTE_W-1:0] blanks[5] = '{CH_SPACE, CH_TAB, CH_VTAB, CH_FFEED, CH_CR};
    logic [BYTE_W-1:0] oddities[10] = '{"a", ".", 8'h00, 8'hFF, CH_PLUS, CH_MINUS,
                                        CH_SPACE, "7", 8'h80, "e"};
    logic [63:0]       bound_vals[11] = '{64'd0, 64'd1, 64'd9, 64'd2147483646,
                                          64'd2147483647, 64'd2147483648,
                                          64'd2147483649, 64'd4294967295,
                                          64'd4294967296, 64'd9999999999,
                                          64'd99999999999};

    csv_integer_field_parser dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_data_byte       (i_data_byte),
        .i_first_byte      (i_first_byte),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_value           (o_value),
        .o_point_index     (o_point_index),
        .o_frame_out       (o_frame_out),
        .o_saturated       (o_saturated),
        .o_beyond_capacity (o_beyond_capacity)
    );

    always #5 i_clk = ~i_clk;

    // Return the field converter to its start state.
    function automatic void clear_field();
        phase = PH_SKIP;
        negative = 1'b0;
        mag = '0;
        clamped = 1'b0;
    endfunction

    // Advance the shadow parser by one byte; a delimiter queues its field.
    function automatic void parse_byte(input logic [BYTE_W-1:0] b, input logic first);
        t_field_result r;
        logic [PROD_W-1:0] acc;
        logic [MAG_W-1:0]  lim;
        logic              blank;
        if (first) begin
            points_seen = '0;
            clear_field();
        end
        blank = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_VTAB) ||
                (b == CH_FFEED) || (b == CH_CR);
        if (b == CH_COMMA || b == CH_NEWLINE) begin
            r.value = negative ? (32'd0 - mag) : mag;
            r.beyond = (points_seen >= CAPACITY);
            r.point_index = r.beyond ? '0 : points_seen[INDEX_W-1:0];
            r.frame = frame_reg;
            r.saturated = clamped;
            pending_fields = {pending_fields, r};
            if (points_seen < CAPACITY) begin
                points_seen++;
            end
            clear_field();
        end else if (phase == PH_SKIP && (b == CH_PLUS || b == CH_MINUS)) begin
            negative = (b == CH_MINUS);
            phase = PH_SIGN;
        end else if (phase != PH_STOP && b >= CH_ZERO && b <= CH_NINE) begin
            lim = negative ? NEG_LIMIT : POS_LIMIT;
            acc = PROD_W'(mag) * PROD_W'(10) + PROD_W'(b - CH_ZERO);
            if (acc > PROD_W'(lim)) begin
                mag = lim;
                clamped = 1'b1;
            end else begin
                mag = acc[MAG_W-1:0];
            end
            phase = PH_DIGITS;
        end else if (!(phase == PH_SKIP && blank)) begin
            // Anything else ends the conversion; leading blanks are skipped.
            phase = PH_STOP;
        end
    endfunction

    // Idle length: mostly short, now and then long.
    function automatic int idle_len();
        if ($urandom_range(0, 99) < 80) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 30);
    endfunction

    function automatic void put(input logic [BYTE_W-1:0] d, input logic first);
        t_byte_req q;
        q.data = d;
        q.first = first;
        byte_reqs = {byte_reqs, q};
    endfunction

    function automatic void put_text(input string s, input logic first);
        for (int k = 0; k < s.len(); k++) begin
            put(s[k], first && k == 0);
        end
    endfunction

    // Queue one random field, mostly well formed; returns the bytes added.
    function automatic int queue_random_field();
        int    n0;
        int    kind;
        int    cnt;
        int    sgn;
        string txt;
        n0 = byte_reqs.size();
        kind = $urandom_range(0, 99);
        if (kind < 10) begin
            // Raw noise, delimiters included.
            cnt = $urandom_range(1, 4);
            for (int k = 0; k < cnt; k++) begin
                put(8'($urandom_range(0, 255)), 1'b0);
            end
        end else begin
            if ($urandom_range(0, 3) == 0) begin
                cnt = $urandom_range(1, 2);
                for (int k = 0; k < cnt; k++) begin
                    put(blanks[$urandom_range(0, 4)], 1'b0);
                end
            end
            sgn = $urandom_range(0, 2);
            if (sgn == 1) begin
                put(CH_PLUS, 1'b0);
            end else if (sgn == 2) begin
                put(CH_MINUS, 1'b0);
            end
            if (kind < 60) begin
                cnt = $urandom_range(0, 10);
                for (int k = 0; k < cnt; k++) begin
                    put(8'($urandom_range(CH_ZERO, CH_NINE)), 1'b0);
                end
            end else if (kind < 80) begin
                txt = $sformatf("%0d", bound_vals[$urandom_range(0, 10)]);
                if ($urandom_range(0, 3) == 0) begin
                    txt = {"00", txt};
                end
                put_text(txt, 1'b0);
            end else if (kind < 88) begin
                cnt = $urandom_range(11, 20);
                for (int k = 0; k < cnt; k++) begin
                    put(8'($urandom_range(CH_ZERO, CH_NINE)), 1'b0);
                end
            end else begin
                cnt = $urandom_range(1, 6);
                for (int k = 0; k < cnt; k++) begin
                    put(oddities[$urandom_range(0, 9)], 1'b0);
                end
            end
            // Occasional junk after the number, possibly followed by digits.
            if ($urandom_range(0, 99) < 15) begin
                put(oddities[$urandom_range(0, 9)], 1'b0);
                put(8'($urandom_range(CH_ZERO, CH_NINE)), 1'b0);
            end
            put(($urandom_range(0, 99) < 70) ? CH_COMMA : CH_NEWLINE, 1'b0);
        end
        // Start a new file now and then, which also drops any open field.
        if (byte_reqs.size() > n0 && $urandom_range(0, 99) < 8) begin
            byte_reqs[n0].first = 1'b1;
        end
        return byte_reqs.size() - n0;
    endfunction

    function automatic void queue_random_text(input int n_bytes);
        int added;
        added = 0;
        while (added < n_bytes) begin
            added += queue_random_field();
        end
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected 0x%0h got 0x%0h", $time, name, want, got);
            errors++;
        end
    endfunction

    // Wait until every byte is taken and every field has come back out.
    task automatic drain();
        do begin
            @(negedge i_clk);
        end while (byte_reqs.size() != 0 || i_in_valid || pending_fields.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    // Write the frame register while the block is idle.
    task automatic set_frame(input logic [FRAME_W-1:0] f);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= f;
        frame_reg = f;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // Byte sender: next request after a taken one, with random gaps.
    always @(negedge i_clk) begin
        t_byte_req nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || byte_taken) begin
            if (send_gap > 0 || byte_reqs.size() == 0) begin
                i_in_valid <= 1'b0;
                if (send_gap > 0) begin
                    send_gap--;
                end
            end else begin
                nxt = byte_reqs.pop_front();
                i_in_valid <= 1'b1;
                i_data_byte <= nxt.data;
                i_first_byte <= nxt.first;
                if (!no_idle && $urandom_range(0, 99) < 40) begin
                    send_gap = idle_len();
                end
            end
        end
    end

    // Result receiver stall pattern.
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left--;
        end else begin
            i_out_stall <= 1'b0;
            if (!no_idle && $urandom_range(0, 99) < 20) begin
                stall_left = idle_len();
            end
        end
    end

    // Monitor: check the result taken at this edge, then predict from the byte taken.
    always @(posedge i_clk) begin
        t_field_result want;
        byte_taken = 1'b0;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_fields.size() == 0) begin
                    $display("%0t: unexpected result value %0d index %0d", $time,
                             $signed(o_value), o_point_index);
                    errors++;
                end else begin
                    want = pending_fields.pop_front();
                    check_field("value", want.value, o_value);
                    check_field("point_index", 32'(want.point_index), 32'(o_point_index));
                    check_field("frame_out", 32'(want.frame), 32'(o_frame_out));
                    check_field("saturated", 32'(want.saturated), 32'(o_saturated));
                    check_field("beyond_capacity", 32'(want.beyond),
                                32'(o_beyond_capacity));
                end
            end
            if (i_in_valid && !o_in_stall) begin
                parse_byte(i_data_byte, i_first_byte);
                byte_taken = 1'b1;
            end
        end
    end

    // Stimulus phases.
    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        set_frame(16'hFFFF);
        // Directed: empty field, blanks and sign, second sign, zero byte,
        // high byte, blank after digits, and a dropped trailing field.
        put(CH_COMMA, 1'b1);
        put(CH_SPACE, 1'b0);
        put(CH_CR, 1'b0);
        put_text("-5x9", 1'b0);
        put(CH_NEWLINE, 1'b0);
        put_text("+-1,", 1'b0);
        put(8'h00, 1'b0);
        put_text("7,", 1'b0);
        put(8'hFF, 1'b0);
        put(CH_COMMA, 1'b0);
        put_text("3 4,", 1'b0);
        put_text("8", 1'b0);
        put(CH_COMMA, 1'b1);
        drain();

        // Random text in phases; the sender pauses until each phase drains.
        set_frame(16'h0000);
        queue_random_text(250);
        drain();
        set_frame(16'($urandom));
        queue_random_text(250);
        drain();
        set_frame(16'($urandom));
        queue_random_text(250);
        drain();

        // A run of empty fields at full rate, a saturated negative field and a short one, then a new file.
        set_frame(16'h8001);
        no_idle = 1'b1;
        for (int k = 0; k < 8; k++) begin
            put(CH_COMMA, k == 0);
        end
        put_text("-99999999999,", 1'b0);
        put_text("12", 1'b0);
        put(CH_NEWLINE, 1'b0);
        put_text("5,", 1'b1);
        drain();
        no_idle = 1'b0;

        repeat (10) @(negedge i_clk);
        if (errors == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

    // Run limit.
    initial begin
        #15000000;
        $display("tb_top NOT OK");
        $finish;
    end

endmodule
